@@ design/hsv_pkg.sv @@
// Shared types and constants for the HSV color converter.
// No dependencies.
package hsv_pkg;

    localparam int VAL_W = 16;
    localparam int HUE_W = 9;
    localparam int BYTE_W = 8;
    localparam int SEC_W = 3;
    localparam int SEC_DEG = 60;
    localparam int HUE_MAX = 360;
    localparam int BYTE_MAX = 255;

    // floor(y/60) == (y*RECIP_60) >> RECIP_SH, exact for y < 2^14
    localparam int Y_W = 14;
    localparam int RECIP_60 = 17477;
    localparam int RECIP_SH = 20;

    localparam logic [SEC_W-1:0] SEC_RY = 3'd0;
    localparam logic [SEC_W-1:0] SEC_YG = 3'd1;
    localparam logic [SEC_W-1:0] SEC_GC = 3'd2;
    localparam logic [SEC_W-1:0] SEC_CB = 3'd3;
    localparam logic [SEC_W-1:0] SEC_BM = 3'd4;
    localparam logic [SEC_W-1:0] SEC_MR = 3'd5;

    typedef struct packed {
        logic             err;
        logic             sat_zero;
        logic [HUE_W-1:0] hue;
        logic [VAL_W-1:0] light;
        logic [VAL_W-1:0] alpha;
    } hsv_side_t;

    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
    } hsv_rgb_t;

endpackage

@@ design/hsv_div.sv @@
// Pipelined restoring divider for HSL saturation, one quotient bit per stage.
// Depends on hsv_pkg.
module hsv_div #(
    parameter int FRAC_BITS = 15
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [31:0]                 vs,
    input  logic [2*FRAC_BITS+1:0]      lnum,
    output logic                        out_valid,
    output logic [FRAC_BITS:0]          quot
);
    import hsv_pkg::*;

    localparam int F  = FRAC_BITS;
    localparam int QB = F + 1;
    localparam int LW = 2 * F + 2;
    localparam int DW = 2 * F + 2;
    localparam int NW = DW + QB;
    localparam logic [LW-1:0] FULL = LW'(1) << (2 * F + 1);

    logic [LW-1:0] lden;
    logic [NW-1:0] n2;

    logic [QB:0]   valid_reg;
    logic [DW-1:0] rem_reg [QB+1];
    logic [QB-1:0] lo_reg  [QB+1];
    logic [DW-1:0] d_reg   [QB+1];
    logic [QB-1:0] q_reg   [QB+1];

    always_comb
    begin
        lden = ({lnum[LW-2:0], 1'b0} < FULL && !lnum[LW-1]) ? lnum : FULL - lnum;
        n2   = (NW'(vs) << (F + 1)) + NW'(lden);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[QB-1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= n2[NW-1:QB];
        lo_reg[0]  <= n2[QB-1:0];
        d_reg[0]   <= DW'({lden, 1'b0});
        q_reg[0]   <= '0;
    end

    for (genvar i = 1; i <= QB; i++)
    begin : g_stage
        logic [DW:0] trial;
        logic        fit;
        assign trial = {rem_reg[i-1], lo_reg[i-1][QB-1]};
        assign fit   = trial >= {1'b0, d_reg[i-1]};
        always_ff @(posedge clk)
        begin
            rem_reg[i] <= fit ? DW'(trial - {1'b0, d_reg[i-1]}) : trial[DW-1:0];
            lo_reg[i]  <= {lo_reg[i-1][QB-2:0], 1'b0};
            d_reg[i]   <= d_reg[i-1];
            q_reg[i]   <= {q_reg[i-1][QB-2:0], fit};
        end
    end

    assign out_valid = valid_reg[QB];
    assign quot      = q_reg[QB];

endmodule

@@ design/hsv_rgb.sv @@
// Three-stage RGB path: channel terms, sector select and scale, divide by 60.
// Depends on hsv_pkg.
module hsv_rgb #(
    parameter int FRAC_BITS = 15
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [31:0]          vs,
    input  logic [15:0]          v,
    input  logic [5:0]           w,
    input  logic [2:0]           sector,
    output logic                 out_valid,
    output hsv_pkg::hsv_rgb_t    rgb
);
    import hsv_pkg::*;

    localparam int F  = FRAC_BITS;
    localparam int CW = F + 40;
    localparam int TW = CW + 8;
    localparam logic [TW-1:0] HALF = TW'(SEC_DEG / 2) << (2 * F);

    logic [2:0]       valid_reg;
    logic [CW-1:0]    cd_reg, xd_reg, md_reg;
    logic [SEC_W-1:0] sec_reg;
    logic [Y_W-1:0]   yr_reg, yg_reg, yb_reg;
    logic [CW-1:0]    cdx, xdx, mdx, rd, gd, bd, cd_full;
    logic [TW-1:0]    tr, tg, tb;

    function automatic logic [BYTE_W-1:0] div60(input logic [Y_W-1:0] y);
        logic [Y_W+15:0] p;
        p = (Y_W+16)'(y) * (Y_W+16)'(RECIP_60);
        return p[RECIP_SH+BYTE_W-1:RECIP_SH];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[1:0], in_valid};
    end

    always_comb
    begin
        cd_full = CW'(vs) * CW'(SEC_DEG);
        cdx = cd_reg;
        xdx = xd_reg + md_reg;
        mdx = md_reg;
        cdx = cd_reg + md_reg;
        rd = mdx;
        gd = mdx;
        bd = mdx;
        case (sec_reg)
            SEC_RY:  begin rd = cdx; gd = xdx; end
            SEC_YG:  begin rd = xdx; gd = cdx; end
            SEC_GC:  begin gd = cdx; bd = xdx; end
            SEC_CB:  begin gd = xdx; bd = cdx; end
            SEC_BM:  begin rd = xdx; bd = cdx; end
            default: begin rd = cdx; bd = xdx; end
        endcase
        tr = TW'(rd) * TW'(BYTE_MAX) + HALF;
        tg = TW'(gd) * TW'(BYTE_MAX) + HALF;
        tb = TW'(bd) * TW'(BYTE_MAX) + HALF;
    end

    always_ff @(posedge clk)
    begin
        cd_reg  <= cd_full;
        xd_reg  <= CW'(vs) * CW'(w);
        md_reg  <= ((CW'(v) << F) * CW'(SEC_DEG)) - cd_full;
        sec_reg <= sector;
        yr_reg  <= tr[2*F+Y_W-1:2*F];
        yg_reg  <= tg[2*F+Y_W-1:2*F];
        yb_reg  <= tb[2*F+Y_W-1:2*F];
        rgb.red   <= div60(yr_reg);
        rgb.green <= div60(yg_reg);
        rgb.blue  <= div60(yb_reg);
    end

    assign out_valid = valid_reg[2];

endmodule

@@ design/hsv_color_converter_core.sv @@
// HSV to RGB and HSL pixel converter, top level.
// One pixel per cycle, busy stays low.
// Done is timed by the saturation divider, one quotient bit per stage; RGB waits to match.
// Asynchronous active-low reset clears the valid bits only; no state to clear.
// Depends on hsv_pkg, hsv_rgb, hsv_div.
module hsv_color_converter_core #(
    parameter int FRAC_BITS = 15
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [hsv_pkg::HUE_W-1:0] hue,
    input  logic [hsv_pkg::VAL_W-1:0] saturation,
    input  logic [hsv_pkg::VAL_W-1:0] brightness,
    input  logic [hsv_pkg::VAL_W-1:0] alpha,
    output logic        done,
    output logic [hsv_pkg::BYTE_W-1:0] red,
    output logic [hsv_pkg::BYTE_W-1:0] green,
    output logic [hsv_pkg::BYTE_W-1:0] blue,
    output logic [hsv_pkg::HUE_W-1:0] hsl_hue,
    output logic [hsv_pkg::VAL_W-1:0] hsl_saturation,
    output logic [hsv_pkg::VAL_W-1:0] lightness,
    output logic [hsv_pkg::VAL_W-1:0] alpha_out,
    output logic        range_error
);
    import hsv_pkg::*;

    localparam int F   = FRAC_BITS;
    localparam int QB  = F + 1;
    localparam int LW  = 2 * F + 2;
    localparam int EW  = F + 18;
    localparam int LAT = QB + 3;
    localparam int RGB_DLY = QB - 2;
    localparam logic [EW-1:0] ONE_E = EW'(1) << F;
    localparam logic [F+1:0]  TWO_ONE = (F+2)'(1) << (F + 1);
    localparam logic [LW-1:0] FULL = LW'(1) << (2 * F + 1);

    logic             valid0_reg, valid1_reg;
    logic [HUE_W-1:0] hue0_reg;
    logic [VAL_W-1:0] s0_reg, v0_reg, a0_reg;
    logic             err0_reg;

    logic [31:0]      vs1_reg;
    logic [LW-1:0]    lnum1_reg;
    logic [VAL_W-1:0] v1_reg;
    logic [5:0]       w1_reg;
    logic [SEC_W-1:0] sec1_reg;
    logic [HUE_W-1:0] hue1_reg;
    logic [VAL_W-1:0] a1_reg;
    logic             err1_reg;

    logic [HUE_W-1:0] rmod, hue_off;
    logic [5:0]       w_next;
    logic [SEC_W-1:0] sec_next;
    logic [F+1:0]     s_comp;
    logic [LW:0]      lsum;
    logic [LW+15:0]   lext;
    hsv_side_t        side_in;
    hsv_side_t        side_reg [QB+1];

    logic             rgb_valid, div_valid;
    hsv_rgb_t         rgb_out;
    hsv_rgb_t         rgb_reg [RGB_DLY];
    logic [QB-1:0]    quot;
    logic [QB+15:0]   qext;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid0_reg <= 1'b0;
            valid1_reg <= 1'b0;
        end
        else
        begin
            valid0_reg <= start;
            valid1_reg <= valid0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        hue0_reg <= hue;
        s0_reg   <= saturation;
        v0_reg   <= brightness;
        a0_reg   <= alpha;
        err0_reg <= (hue > HUE_W'(HUE_MAX)) || (EW'(saturation) > ONE_E)
                    || (EW'(brightness) > ONE_E) || (EW'(alpha) > ONE_E);
    end

    always_comb
    begin
        if (hue0_reg >= HUE_W'(4 * SEC_DEG))
            rmod = hue0_reg - HUE_W'(4 * SEC_DEG);
        else if (hue0_reg >= HUE_W'(2 * SEC_DEG))
            rmod = hue0_reg - HUE_W'(2 * SEC_DEG);
        else
            rmod = hue0_reg;
        hue_off = (rmod >= HUE_W'(SEC_DEG)) ? rmod - HUE_W'(SEC_DEG)
                                            : HUE_W'(SEC_DEG) - rmod;
        w_next = 6'(HUE_W'(SEC_DEG) - hue_off);
        if (hue0_reg < HUE_W'(SEC_DEG))
            sec_next = SEC_RY;
        else if (hue0_reg < HUE_W'(2 * SEC_DEG))
            sec_next = SEC_YG;
        else if (hue0_reg < HUE_W'(3 * SEC_DEG))
            sec_next = SEC_GC;
        else if (hue0_reg < HUE_W'(4 * SEC_DEG))
            sec_next = SEC_CB;
        else if (hue0_reg < HUE_W'(5 * SEC_DEG))
            sec_next = SEC_BM;
        else
            sec_next = SEC_MR;
        s_comp = TWO_ONE - (F+2)'(s0_reg);
    end

    always_ff @(posedge clk)
    begin
        vs1_reg   <= 32'(v0_reg) * 32'(s0_reg);
        lnum1_reg <= LW'((F+18)'(v0_reg) * (F+18)'(s_comp));
        v1_reg    <= v0_reg;
        w1_reg    <= w_next;
        sec1_reg  <= sec_next;
        hue1_reg  <= hue0_reg;
        a1_reg    <= a0_reg;
        err1_reg  <= err0_reg;
    end

    always_comb
    begin
        lsum = (LW+1)'(lnum1_reg) + ((LW+1)'(1) << F);
        lext = (LW+16)'(lsum >> (F + 1));
        side_in.err      = err1_reg;
        side_in.sat_zero = (lnum1_reg == '0) || (lnum1_reg == FULL);
        side_in.hue      = hue1_reg;
        side_in.light    = lext[15:0];
        side_in.alpha    = a1_reg;
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_in;
        for (int i = 1; i <= QB; i++)
            side_reg[i] <= side_reg[i-1];
    end

    hsv_rgb #(.FRAC_BITS(F)) u_rgb (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid1_reg),
        .vs        (vs1_reg),
        .v         (v1_reg),
        .w         (w1_reg),
        .sector    (sec1_reg),
        .out_valid (rgb_valid),
        .rgb       (rgb_out)
    );

    hsv_div #(.FRAC_BITS(F)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid1_reg),
        .vs        (vs1_reg),
        .lnum      (lnum1_reg),
        .out_valid (div_valid),
        .quot      (quot)
    );

    always_ff @(posedge clk)
    begin
        rgb_reg[0] <= rgb_out;
        for (int i = 1; i < RGB_DLY; i++)
            rgb_reg[i] <= rgb_reg[i-1];
    end

    assign qext = (QB+16)'(quot);

    always_comb
    begin
        done           = div_valid;
        range_error    = side_reg[QB].err;
        red            = side_reg[QB].err ? '0 : rgb_reg[RGB_DLY-1].red;
        green          = side_reg[QB].err ? '0 : rgb_reg[RGB_DLY-1].green;
        blue           = side_reg[QB].err ? '0 : rgb_reg[RGB_DLY-1].blue;
        hsl_hue        = side_reg[QB].err ? '0 : side_reg[QB].hue;
        lightness      = side_reg[QB].err ? '0 : side_reg[QB].light;
        alpha_out      = side_reg[QB].err ? '0 : side_reg[QB].alpha;
        hsl_saturation = (side_reg[QB].err || side_reg[QB].sat_zero) ? '0 : qext[15:0];
    end

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##(LAT) done)
        else $error("transfer did not complete at expected latency");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result without a matching transfer");

    a_rgb_align: assert property (@(posedge clk) disable iff (!rst_n)
        rgb_valid |-> ##(RGB_DLY) div_valid)
        else $error("rgb path out of step with divider");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && range_error) |-> (red == '0 && hsl_saturation == '0 && lightness == '0))
        else $error("error result carries data");

endmodule

@@ sim/hsv_color_converter_core_tb.sv @@
// Testbench for hsv_color_converter_core: directed and random HSV pixels,
// each result checked against a behavioral HSV to RGB/HSL predictor.
// Depends on hsv_pkg and the hsv_color_converter_core RTL.
module hsv_color_converter_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import hsv_pkg::*;

    localparam int FRAC_BITS = 15;
    localparam longint ONE = 64'd1 << FRAC_BITS;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic [HUE_W-1:0]  hue;
        logic [VAL_W-1:0]  sat;
        logic [VAL_W-1:0]  light;
        logic [VAL_W-1:0]  alpha;
        logic              err;
    } pixel_out_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [HUE_W-1:0] hue = '0;
    logic [VAL_W-1:0] saturation = '0;
    logic [VAL_W-1:0] brightness = '0;
    logic [VAL_W-1:0] alpha = '0;
    logic done;
    logic [BYTE_W-1:0] red, green, blue;
    logic [HUE_W-1:0] hsl_hue;
    logic [VAL_W-1:0] hsl_saturation, lightness, alpha_out;
    logic range_error;

    pixel_out_t pending_pixels[$];
    int errors = 0;
    int pixels_sent = 0;
    int pixels_checked = 0;
    int idle_cycles = 0;
    int error_pixels = 0;
    bit no_gaps = 1'b0;

    hsv_color_converter_core #(.FRAC_BITS(FRAC_BITS)) u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .hue(hue), .saturation(saturation), .brightness(brightness), .alpha(alpha),
        .done(done), .red(red), .green(green), .blue(blue),
        .hsl_hue(hsl_hue), .hsl_saturation(hsl_saturation), .lightness(lightness),
        .alpha_out(alpha_out), .range_error(range_error)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic longint rnd_div(longint num, longint den);
        if (den == 0)
            return 0;
        return (2 * num + den) / (2 * den);
    endfunction

    function automatic pixel_out_t convert_pixel(logic [HUE_W-1:0] h, logic [VAL_W-1:0] s_in,
                                                 logic [VAL_W-1:0] v_in, logic [VAL_W-1:0] a_in);
        pixel_out_t p;
        longint s, v, scale, chroma, base, rem, hue_off, xpart, rr, gg, bb, lnum, full, lden;
        s = s_in;
        v = v_in;
        p = '{default: '0};
        if (h > HUE_MAX || s > ONE || v > ONE || a_in > ONE)
        begin
            p.err = 1'b1;
            return p;
        end
        scale = ONE * ONE * SEC_DEG;
        chroma = v * s * SEC_DEG;
        base = v * ONE * SEC_DEG - chroma;
        rem = h % (2 * SEC_DEG);
        hue_off = (rem >= SEC_DEG) ? rem - SEC_DEG : SEC_DEG - rem;
        xpart = v * s * (SEC_DEG - hue_off);
        if (h < 60)
        begin
            rr = chroma + base; gg = xpart + base; bb = base;
        end
        else if (h < 120)
        begin
            rr = xpart + base; gg = chroma + base; bb = base;
        end
        else if (h < 180)
        begin
            rr = base; gg = chroma + base; bb = xpart + base;
        end
        else if (h < 240)
        begin
            rr = base; gg = xpart + base; bb = chroma + base;
        end
        else if (h < 300)
        begin
            rr = xpart + base; gg = base; bb = chroma + base;
        end
        else
        begin
            rr = chroma + base; gg = base; bb = xpart + base;
        end
        p.red = BYTE_W'(rnd_div(BYTE_MAX * rr, scale));
        p.green = BYTE_W'(rnd_div(BYTE_MAX * gg, scale));
        p.blue = BYTE_W'(rnd_div(BYTE_MAX * bb, scale));
        full = 2 * ONE * ONE;
        lnum = v * (2 * ONE - s);
        p.light = VAL_W'(rnd_div(lnum, 2 * ONE));
        if (lnum == 0 || lnum == full)
            p.sat = '0;
        else
        begin
            lden = (2 * lnum < full) ? lnum : full - lnum;
            p.sat = VAL_W'(rnd_div(v * s * ONE, lden));
        end
        p.hue = h;
        p.alpha = a_in;
        return p;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("MISMATCH pixel %0d %s: got %0d expected %0d", pixels_checked, what, got, want);
    endtask

    task automatic send_pixel(logic [HUE_W-1:0] h, logic [VAL_W-1:0] s,
                              logic [VAL_W-1:0] v, logic [VAL_W-1:0] a);
        while (!no_gaps && $urandom_range(99) < 17)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        hue <= h;
        saturation <= s;
        brightness <= v;
        alpha <= a;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_pixels.push_back(convert_pixel(h, s, v, a));
        if (h > HUE_MAX || s > ONE || v > ONE || a > ONE)
            error_pixels++;
        pixels_sent++;
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        pixel_out_t want;
        if (rst_n && done)
        begin
            if (pending_pixels.size() == 0)
                report_mismatch("unexpected result transfer", 1, 0);
            else
            begin
                want = pending_pixels.pop_front();
                if (red !== want.red) report_mismatch("red", red, want.red);
                if (green !== want.green) report_mismatch("green", green, want.green);
                if (blue !== want.blue) report_mismatch("blue", blue, want.blue);
                if (hsl_hue !== want.hue) report_mismatch("hsl_hue", hsl_hue, want.hue);
                if (hsl_saturation !== want.sat)
                    report_mismatch("hsl_saturation", hsl_saturation, want.sat);
                if (lightness !== want.light) report_mismatch("lightness", lightness, want.light);
                if (alpha_out !== want.alpha) report_mismatch("alpha_out", alpha_out, want.alpha);
                if (range_error !== want.err)
                    report_mismatch("range_error", range_error, want.err);
            end
            pixels_checked++;
        end
    end

    // stalls only count while something is outstanding or being offered
    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n || (!start && pending_pixels.size() == 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired");
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [VAL_W-1:0] rand_frac();
        int pick;
        pick = $urandom_range(99);
        if (pick < 8)
            return VAL_W'(ONE);
        if (pick < 14)
            return '0;
        return VAL_W'($urandom_range(32'(ONE)));
    endfunction

    task automatic test_extremes();
        send_pixel(0, 0, 0, 0);
        send_pixel(0, ONE, ONE, ONE);
        send_pixel(HUE_MAX, ONE, ONE, ONE);
        send_pixel(0, 0, ONE, ONE);
        send_pixel(180, ONE / 2, ONE / 2, 12345);
        send_pixel(90, ONE, ONE / 2, 0);
        send_pixel(359, 1, ONE - 1, 1);
    endtask

    task automatic test_sectors();
        int h;
        for (h = 0; h <= HUE_MAX; h += 30)
            send_pixel(HUE_W'(h), VAL_W'($urandom_range(32'(ONE))),
                       VAL_W'($urandom_range(32'(ONE))), VAL_W'($urandom_range(32'(ONE))));
        send_pixel(59, ONE, ONE, ONE);
        send_pixel(60, ONE, ONE, ONE);
        send_pixel(300, ONE, ONE, ONE);
    endtask

    task automatic test_range_errors();
        send_pixel(HUE_MAX + 1, 0, 0, 0);
        send_pixel(9'h1FF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(0, ONE + 1, 0, 0);
        send_pixel(0, 0, ONE + 1, 0);
        send_pixel(0, 0, 0, ONE + 1);
    endtask

    task automatic test_random(int count);
        int n;
        for (n = 0; n < count; n++)
        begin
            no_gaps = (n >= count / 3 && n < count / 2);
            if ($urandom_range(99) < 6)
                send_pixel(HUE_W'($urandom), VAL_W'($urandom), VAL_W'($urandom),
                           VAL_W'($urandom));
            else
                send_pixel(HUE_W'($urandom_range(HUE_MAX)), rand_frac(), rand_frac(),
                           rand_frac());
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_extremes();
        test_sectors();
        test_range_errors();
        test_random(680);
        start <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (FRAC_BITS + 10) @(posedge clk);
        $display("Sent %0d pixels (%0d out of range), checked %0d results.",
                 pixels_sent, error_pixels, pixels_checked);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
